// ===== hdl/dspwm_pkg.sv =====
`default_nettype none
package dspwm_pkg;

    localparam int PWM_STEPS_DEF   = 8;
    localparam int DUTY_LEVELS_DEF = 5;

    localparam int DB_W    = 16;
    localparam int DUTY_W  = 4;

    localparam logic [DB_W-1:0] DEBOUNCE_RESET = 16'd25;

    typedef enum logic [1:0] {
        PH_IDLE         = 2'd0,
        PH_WAIT_PRESS   = 2'd1,
        PH_STABLE       = 2'd2,
        PH_WAIT_RELEASE = 2'd3
    } t_db_phase;

    typedef struct packed {
        logic press;
        logic pressed;
    } t_db_status;

endpackage
`default_nettype wire

// ===== hdl/dspwm_if.sv =====
`default_nettype none
interface dspwm_in_if;
    import dspwm_pkg::*;

    logic valid;
    logic ready;
    logic cmd;
    logic button_pressed;

    modport source (output valid, output cmd, output button_pressed, input ready);
    modport sink   (input valid, input cmd, input button_pressed, output ready);
endinterface

interface dspwm_out_if;
    import dspwm_pkg::*;

    logic              valid;
    logic              ready;
    logic              pwm_out;
    logic [DUTY_W-1:0] duty_level;
    logic              press_event;
    logic              debounced_pressed;

    modport source (output valid, output pwm_out, output duty_level, output press_event,
                    output debounced_pressed, input ready);
    modport sink   (input valid, input pwm_out, input duty_level, input press_event,
                    input debounced_pressed, output ready);
endinterface
`default_nettype wire

// ===== hdl/dspwm_debounce.sv =====
`default_nettype none
module dspwm_debounce (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_sample,
    input  wire logic                       i_raw,
    input  wire logic [dspwm_pkg::DB_W-1:0] i_count,
    output dspwm_pkg::t_db_status           o_status
);
    import dspwm_pkg::*;

    t_db_phase       r_phase;
    t_db_phase       n_phase;
    logic [DB_W-1:0] r_timer;
    logic [DB_W-1:0] n_timer;
    logic [DB_W-1:0] w_tinc;
    logic            w_expired;
    logic            w_press;

    assign w_tinc    = r_timer + 16'd1;
    assign w_expired = (w_tinc >= i_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_timer <= '0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        w_press = 1'b0;
        if (i_sample) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_raw) begin
                        n_timer = '0;
                        n_phase = PH_WAIT_PRESS;
                    end
                end
                PH_WAIT_PRESS: begin
                    if (i_raw) begin
                        n_timer = w_tinc;
                        if (w_expired) begin
                            n_phase = PH_STABLE;
                            w_press = 1'b1;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_STABLE: begin
                    if (!i_raw) begin
                        n_timer = '0;
                        n_phase = PH_WAIT_RELEASE;
                    end
                end
                PH_WAIT_RELEASE: begin
                    if (!i_raw) begin
                        n_timer = w_tinc;
                        if (w_expired) begin
                            n_phase = PH_IDLE;
                        end
                    end else begin
                        n_phase = PH_STABLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_status.press   = w_press;
    assign o_status.pressed = (n_phase == PH_STABLE) || (n_phase == PH_WAIT_RELEASE);

endmodule
`default_nettype wire

// ===== hdl/debounced_stepped_pwm_unit.sv =====
`default_nettype none
// Software-style PWM stepped by a debounced button. Each input transfer is a PWM tick
// (cmd=0) or a button sample (cmd=1) and yields exactly one result transfer in the cycle
// after. One item is taken every cycle while results are taken as they appear. A result
// that waits holds the input off. The next item enters in the cycle the waiting result
// is taken. A press or release counts once the new level has been seen for
// debounce_count + 1 samples in a row (zero acts as one). Each clean press
// moves the duty one step, ping-pong, through DUTY_LEVELS levels spread from 0 to
// PWM_STEPS; a tick advances the period counter and drives pwm_out high while the
// counter is below the duty. duty_level reports the low four bits of the duty.
module debounced_stepped_pwm_unit #(
    parameter int PWM_STEPS   = dspwm_pkg::PWM_STEPS_DEF,
    parameter int DUTY_LEVELS = dspwm_pkg::DUTY_LEVELS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [dspwm_pkg::DB_W-1:0] i_cfg_wdata,
    dspwm_in_if.sink                        i_in,
    dspwm_out_if.source                     o_out
);
    import dspwm_pkg::*;

    localparam int CW     = (PWM_STEPS > 1) ? $clog2(PWM_STEPS) : 1;
    localparam int DW     = $clog2(PWM_STEPS + 1);
    localparam int LW     = (DUTY_LEVELS > 1) ? $clog2(DUTY_LEVELS) : 1;
    localparam int TAB_N  = 2 ** LW;
    localparam logic [LW:0] TOP_IDX = (LW+1)'(DUTY_LEVELS - 1);
    localparam logic [CW:0] STEPS_C = (CW+1)'(PWM_STEPS);

    logic [DW-1:0] w_duty_tab [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_tab
        if (gi < DUTY_LEVELS) begin : g_used
            assign w_duty_tab[gi] = DW'((gi * PWM_STEPS) / (DUTY_LEVELS - 1));
        end else begin : g_unused
            assign w_duty_tab[gi] = '0;
        end
    end

    logic [DB_W-1:0] r_debounce_count;
    logic [LW-1:0]   r_level_idx;
    logic [LW-1:0]   n_level_idx;
    logic            r_step_up;
    logic            n_step_up;
    logic [CW-1:0]   r_period_cnt;
    logic [CW-1:0]   n_period_cnt;
    logic [DW-1:0]   r_active_duty;
    logic [DW-1:0]   n_active_duty;
    logic            r_pwm_level;
    logic            n_pwm_level;

    logic              r_out_valid;
    logic              r_out_pwm;
    logic [DUTY_W-1:0] r_out_duty;
    logic              r_out_press;
    logic              r_out_pressed;

    logic          w_in_ready;
    logic          w_acc;
    t_db_status    w_db;
    logic [LW:0]   w_idx_step;
    logic [CW:0]   w_cnt_inc;
    logic [DW+DUTY_W-1:0] w_duty_ext;

    assign w_in_ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && w_in_ready;
    assign i_in.ready = w_in_ready;

    dspwm_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (w_acc && i_in.cmd),
        .i_raw    (i_in.button_pressed),
        .i_count  (r_debounce_count),
        .o_status (w_db)
    );

    always_comb begin
        n_level_idx   = r_level_idx;
        n_step_up     = r_step_up;
        n_active_duty = r_active_duty;
        n_period_cnt  = r_period_cnt;
        n_pwm_level   = r_pwm_level;
        w_idx_step    = {1'b0, r_level_idx};
        w_cnt_inc     = {1'b0, r_period_cnt} + (CW+1)'(1);
        if (w_acc && !i_in.cmd) begin
            n_period_cnt = (w_cnt_inc >= STEPS_C) ? '0 : w_cnt_inc[CW-1:0];
            n_pwm_level  = ({{(DW+1){1'b0}}, n_period_cnt} <
                            {{(CW+1){1'b0}}, r_active_duty});
        end
        if (w_db.press) begin
            if (r_step_up) begin
                w_idx_step = {1'b0, r_level_idx} + (LW+1)'(1);
            end else if (r_level_idx != '0) begin
                w_idx_step = {1'b0, r_level_idx} - (LW+1)'(1);
            end
            if (w_idx_step >= TOP_IDX) begin
                n_level_idx = TOP_IDX[LW-1:0];
                n_step_up   = 1'b0;
            end else begin
                n_level_idx = w_idx_step[LW-1:0];
                if (w_idx_step == '0) begin
                    n_step_up = 1'b1;
                end
            end
            n_active_duty = w_duty_tab[n_level_idx];
        end
    end

    assign w_duty_ext = {{DUTY_W{1'b0}}, n_active_duty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_count <= DEBOUNCE_RESET;
            r_level_idx      <= '0;
            r_step_up        <= 1'b1;
            r_period_cnt     <= '0;
            r_active_duty    <= '0;
            r_pwm_level      <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_debounce_count <= i_cfg_wdata;
            end
            r_level_idx   <= n_level_idx;
            r_step_up     <= n_step_up;
            r_period_cnt  <= n_period_cnt;
            r_active_duty <= n_active_duty;
            r_pwm_level   <= n_pwm_level;
            if (w_in_ready) begin
                r_out_valid <= i_in.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_pwm     <= n_pwm_level;
            r_out_duty    <= w_duty_ext[DUTY_W-1:0];
            r_out_press   <= w_db.press;
            r_out_pressed <= w_db.pressed;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.pwm_out           = r_out_pwm;
    assign o_out.duty_level        = r_out_duty;
    assign o_out.press_event       = r_out_press;
    assign o_out.debounced_pressed = r_out_pressed;

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out_duty))
        else $error("result dropped while stalled");

    a_tick_keeps_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_in.cmd |=> $stable(r_level_idx) && $stable(r_step_up))
        else $error("tick changed duty level");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_level_idx} <= TOP_IDX)
        else $error("level index out of range");

    a_duty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active_duty == w_duty_tab[r_level_idx])
        else $error("active duty does not match level");

    a_press_only_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_db.press |-> w_acc && i_in.cmd && i_in.button_pressed)
        else $error("press without pressed sample");

endmodule
`default_nettype wire
